[sv/tte_pkg.sv]
// Shared types and constants of the text terminal character engine.
// No dependencies; the files that use it refer to it by scoped names.
package tte_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BLANK     = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'h07;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } tte_kind_e;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_TAB,
    OP_SET_CURSOR,
    OP_CLEAR,
    OP_READ,
    OP_REPORT
  } tte_op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_TAB,
    S_SCROLL,
    S_FILL,
    S_READ,
    S_DONE
  } tte_state_e;

  typedef struct packed {
    tte_op_e            op;
    logic [7:0]         ch;
    logic               x_ok;
    logic               y_ok;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [ADDR_W-1:0]  addr;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic init_done;
  } tte_status_t;

endpackage

[sv/tte_req_if.sv]
// Request channel: one terminal operation per request.
// Field widths are fixed; no package dependency.
interface tte_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] character;
  logic [7:0] pos_x;
  logic [7:0] pos_y;

  modport source(output valid, kind, character, pos_x, pos_y, input ready);
  modport sink(input valid, kind, character, pos_x, pos_y, output ready);
endinterface

[sv/tte_res_if.sv]
// Result channel: cursor state and cell contents after each request.
// Field widths are fixed; no package dependency.
interface tte_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_offset;
  logic        scrolled;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  modport source(output valid, cursor_col, cursor_row, cursor_offset, scrolled,
                 cell_char, cell_attr, input ready);
  modport sink(input valid, cursor_col, cursor_row, cursor_offset, scrolled,
               cell_char, cell_attr, output ready);
endinterface

[sv/tte_cfg_if.sv]
// Configuration write channel for the text attribute register.
// No package dependency.
interface tte_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[sv/tte_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package dependency.
module tte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tte_front.sv]
// Front end: accepts requests, decodes them into commands, two-entry queue.
// Depends on tte_pkg and tte_req_if.
module tte_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tte_req_if.sink              req_i,
  input  tte_pkg::tte_status_t status_i,
  input  logic                 pop_i,
  output tte_pkg::q_head_t     head_o
);

  tte_pkg::cmd_t cmd;
  tte_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push;
  logic          pop;
  logic [15:0]   rd_ofs;

  assign rd_ofs = 16'(req_i.pos_x) + 16'(tte_pkg::COLS) * 16'(req_i.pos_y);

  always_comb begin
    cmd.op   = tte_pkg::OP_REPORT;
    cmd.ch   = req_i.character;
    cmd.x_ok = (req_i.pos_x < 8'(tte_pkg::COLS));
    cmd.y_ok = (req_i.pos_y < 8'(tte_pkg::ROWS));
    cmd.col  = req_i.pos_x[tte_pkg::COL_W-1:0];
    cmd.row  = req_i.pos_y[tte_pkg::ROW_W-1:0];
    cmd.addr = rd_ofs[tte_pkg::ADDR_W-1:0];
    case (tte_pkg::tte_kind_e'(req_i.kind))
      tte_pkg::KIND_PUT: begin
        case (req_i.character)
          tte_pkg::CH_NEWLINE:   cmd.op = tte_pkg::OP_NEWLINE;
          tte_pkg::CH_BACKSPACE: cmd.op = tte_pkg::OP_BACKSPACE;
          tte_pkg::CH_TAB:       cmd.op = tte_pkg::OP_TAB;
          default:               cmd.op = tte_pkg::OP_CHAR;
        endcase
      end
      tte_pkg::KIND_SET:   cmd.op = tte_pkg::OP_SET_CURSOR;
      tte_pkg::KIND_CLEAR: cmd.op = tte_pkg::OP_CLEAR;
      tte_pkg::KIND_READ: begin
        // out-of-range read only reports the cursor
        cmd.op = (cmd.x_ok && cmd.y_ok) ? tte_pkg::OP_READ : tte_pkg::OP_REPORT;
      end
      default: cmd.op = tte_pkg::OP_REPORT;
    endcase
  end

  assign req_i.ready = (count_q != 2'd2) && status_i.init_done;
  assign push        = req_i.valid && req_i.ready;
  assign pop         = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = entry_q[rd_ptr_q];

endmodule

[sv/tte_back.sv]
// Back end: sequencer that owns cursor, screen buffer and result register.
// Depends on tte_pkg, tte_ram, tte_cfg_if and tte_res_if.
module tte_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tte_cfg_if.sink              cfg_i,
  tte_res_if.source            res_o,
  input  tte_pkg::q_head_t     head_i,
  output logic                 pop_o,
  output tte_pkg::tte_status_t status_o
);

  localparam int AW = tte_pkg::ADDR_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(tte_pkg::NCELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(tte_pkg::NCELLS - tte_pkg::COLS);

  typedef struct packed {
    logic [tte_pkg::COL_W-1:0] col;
    logic [tte_pkg::ROW_W-1:0] row;
    logic                      scroll;
  } adv_t;

  // column overflow wraps, row overflow pins to the last row and scrolls
  function automatic adv_t wrap_cursor(logic [7:0] c, logic [5:0] r);
    adv_t       a;
    logic [7:0] cc;
    logic [5:0] rr;
    cc       = c;
    rr       = r;
    a.scroll = 1'b0;
    if (cc >= 8'(tte_pkg::COLS)) begin
      cc = 8'd0;
      rr = rr + 6'd1;
    end
    if (rr >= 6'(tte_pkg::ROWS)) begin
      rr       = 6'(tte_pkg::ROWS - 1);
      a.scroll = 1'b1;
    end
    a.col = cc[tte_pkg::COL_W-1:0];
    a.row = rr[tte_pkg::ROW_W-1:0];
    return a;
  endfunction

  tte_pkg::tte_state_e state_q, state_d;
  logic [tte_pkg::COL_W-1:0]  col_q, col_d;
  logic [tte_pkg::ROW_W-1:0]  row_q, row_d;
  logic [AW-1:0]              scan_q, scan_d;
  logic                       wr_pend_q, wr_pend_d;
  logic [AW-1:0]              wr_addr_q, wr_addr_d;
  logic                       scrolled_q, scrolled_d;
  logic [tte_pkg::CELL_W-1:0] cell_q, cell_d;
  logic [7:0]                 attr_q;
  logic                       res_valid_q, res_valid_d;
  logic                       res_load;
  logic [6:0]                 res_col_q;
  logic [4:0]                 res_row_q;
  logic [10:0]                res_ofs_q;
  logic                       res_scr_q;
  logic [tte_pkg::CELL_W-1:0] res_cell_q;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tte_pkg::CELL_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [tte_pkg::CELL_W-1:0] rdata;

  logic [12:0]                cur_ofs;
  logic [12:0]                bs_ofs;
  logic [tte_pkg::COL_W-1:0]  bs_col;
  logic [tte_pkg::ROW_W-1:0]  bs_row;
  logic [7:0]                 col_inc;
  logic [5:0]                 row6;
  logic                       tab_more;
  logic [tte_pkg::CELL_W-1:0] blank;
  adv_t                       adv;
  tte_pkg::cmd_t              cmd;

  assign cmd      = head_i.cmd;
  assign blank    = {attr_q, tte_pkg::CH_BLANK};
  assign cur_ofs  = 13'(col_q) + 13'(tte_pkg::COLS) * 13'(row_q);
  assign col_inc  = 8'(col_q) + 8'd1;
  assign row6     = 6'(row_q);
  assign tab_more = (col_inc[1:0] != 2'd0) && (col_inc < 8'(tte_pkg::COLS));

  always_comb begin
    bs_col = col_q;
    bs_row = row_q;
    if (col_q == '0) begin
      if (row_q != '0) begin
        bs_row = row_q - tte_pkg::ROW_W'(1);
        bs_col = tte_pkg::COL_W'(tte_pkg::COLS - 1);
      end
    end else begin
      bs_col = col_q - tte_pkg::COL_W'(1);
    end
  end

  assign bs_ofs = 13'(bs_col) + 13'(tte_pkg::COLS) * 13'(bs_row);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    scan_d      = scan_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    scrolled_d  = scrolled_q;
    cell_d      = cell_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_load    = 1'b0;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = cur_ofs[AW-1:0];
    wdata       = blank;
    re          = 1'b0;
    raddr       = scan_q + AW'(tte_pkg::COLS);
    adv         = wrap_cursor(col_inc, row6);

    case (state_q)
      tte_pkg::S_INIT: begin
        we     = 1'b1;
        waddr  = scan_q;
        wdata  = '0;
        scan_d = scan_q + AW'(1);
        if (scan_q == LAST_ADDR) begin
          state_d = tte_pkg::S_IDLE;
        end
      end

      tte_pkg::S_IDLE: begin
        if (head_i.valid && !res_valid_q) begin
          pop_o      = 1'b1;
          scrolled_d = 1'b0;
          cell_d     = '0;
          state_d    = tte_pkg::S_DONE;
          case (cmd.op)
            tte_pkg::OP_CHAR, tte_pkg::OP_NEWLINE: begin
              if (cmd.op == tte_pkg::OP_CHAR) begin
                we    = 1'b1;
                wdata = {attr_q, cmd.ch};
              end else begin
                adv = wrap_cursor(8'd0, row6 + 6'd1);
              end
              col_d = adv.col;
              row_d = adv.row;
              if (adv.scroll) begin
                scrolled_d = 1'b1;
                scan_d     = '0;
                wr_pend_d  = 1'b0;
                state_d    = tte_pkg::S_SCROLL;
              end
            end
            tte_pkg::OP_BACKSPACE: begin
              we    = 1'b1;
              waddr = bs_ofs[AW-1:0];
              col_d = bs_col;
              row_d = bs_row;
            end
            tte_pkg::OP_TAB: begin
              we = 1'b1;
              if (tab_more) begin
                col_d   = col_inc[tte_pkg::COL_W-1:0];
                state_d = tte_pkg::S_TAB;
              end else begin
                col_d = adv.col;
                row_d = adv.row;
                if (adv.scroll) begin
                  scrolled_d = 1'b1;
                  scan_d     = '0;
                  wr_pend_d  = 1'b0;
                  state_d    = tte_pkg::S_SCROLL;
                end
              end
            end
            tte_pkg::OP_SET_CURSOR: begin
              if (cmd.x_ok) begin
                col_d = cmd.col;
              end
              if (cmd.y_ok) begin
                row_d = cmd.row;
              end
            end
            tte_pkg::OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              scan_d  = '0;
              state_d = tte_pkg::S_FILL;
            end
            tte_pkg::OP_READ: begin
              re      = 1'b1;
              raddr   = cmd.addr;
              state_d = tte_pkg::S_READ;
            end
            default: state_d = tte_pkg::S_DONE;
          endcase
        end
      end

      tte_pkg::S_TAB: begin
        we = 1'b1;
        if (tab_more) begin
          col_d = col_inc[tte_pkg::COL_W-1:0];
        end else begin
          col_d   = adv.col;
          row_d   = adv.row;
          state_d = tte_pkg::S_DONE;
          if (adv.scroll) begin
            scrolled_d = 1'b1;
            scan_d     = '0;
            wr_pend_d  = 1'b0;
            state_d    = tte_pkg::S_SCROLL;
          end
        end
      end

      tte_pkg::S_SCROLL: begin
        // read one row ahead, write the previous read in the next cycle
        if (wr_pend_q) begin
          we    = 1'b1;
          waddr = wr_addr_q;
          wdata = rdata;
        end
        if (scan_q != COPY_END) begin
          re        = 1'b1;
          wr_addr_d = scan_q;
          wr_pend_d = 1'b1;
          scan_d    = scan_q + AW'(1);
        end else begin
          wr_pend_d = 1'b0;
          state_d   = tte_pkg::S_FILL;
        end
      end

      tte_pkg::S_FILL: begin
        we     = 1'b1;
        waddr  = scan_q;
        scan_d = scan_q + AW'(1);
        if (scan_q == LAST_ADDR) begin
          state_d = tte_pkg::S_DONE;
        end
      end

      tte_pkg::S_READ: begin
        cell_d  = rdata;
        state_d = tte_pkg::S_DONE;
      end

      tte_pkg::S_DONE: begin
        res_load    = 1'b1;
        res_valid_d = 1'b1;
        state_d     = tte_pkg::S_IDLE;
      end

      default: state_d = tte_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tte_pkg::S_INIT;
      col_q       <= '0;
      row_q       <= '0;
      scan_q      <= '0;
      wr_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
      attr_q      <= tte_pkg::ATTR_RESET;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      scan_q      <= scan_d;
      wr_pend_q   <= wr_pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid) begin
        attr_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q  <= wr_addr_d;
    scrolled_q <= scrolled_d;
    cell_q     <= cell_d;
    if (res_load) begin
      res_col_q  <= 7'(col_q);
      res_row_q  <= 5'(row_q);
      res_ofs_q  <= cur_ofs[10:0];
      res_scr_q  <= scrolled_q;
      res_cell_q <= cell_q;
    end
  end

  tte_ram #(
    .WIDTH(tte_pkg::CELL_W),
    .DEPTH(tte_pkg::NCELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cfg_i.ready        = 1'b1;
  assign status_o.init_done = (state_q != tte_pkg::S_INIT);

  assign res_o.valid         = res_valid_q;
  assign res_o.cursor_col    = res_col_q;
  assign res_o.cursor_row    = res_row_q;
  assign res_o.cursor_offset = res_ofs_q;
  assign res_o.scrolled      = res_scr_q;
  assign res_o.cell_char     = res_cell_q[7:0];
  assign res_o.cell_attr     = res_cell_q[15:8];

endmodule

[sv/text_terminal_char_engine_core.sv]
// Top level of the text terminal character engine: front decoder/queue plus
// back sequencer. Depends on tte_pkg, the tte_*_if interfaces, tte_front, tte_back.
//
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    kind, character, pos_x, pos_y
//  cfg_i    in   valid/ready    data (text attribute), always ready
//  res_o    out  valid/ready    cursor_col/row/offset, scrolled, cell_char/attr
//
// Printable char, newline, backspace, set cursor: S_IDLE, then S_DONE.
// Tab writes up to 3 extra blanks in S_TAB, read cell passes through S_READ.
// Scroll copies each row up one in S_SCROLL, then blank-fills the last row in S_FILL;
// clear screen blank-fills all NCELLS cells (2000 at 80x25) in S_FILL.
// After reset a clearing pass zeroes all NCELLS cells of the buffer, ready low.
// A stalled result holds the back end; req_i.ready drops once the queue is full.
module text_terminal_char_engine_core (
  input logic       clk_i,
  input logic       rst_ni,
  tte_req_if.sink   req_i,
  tte_cfg_if.sink   cfg_i,
  tte_res_if.source res_o
);

  tte_pkg::q_head_t     head;
  tte_pkg::tte_status_t status;
  logic                 pop;

  tte_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .status_i(status),
    .pop_i   (pop),
    .head_o  (head)
  );

  tte_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .res_o   (res_o),
    .head_i  (head),
    .pop_o   (pop),
    .status_o(status)
  );

  a_no_req_during_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.init_done |-> !req_i.ready)
    else $error("request taken during buffer clearing pass");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.cursor_col < 7'(tte_pkg::COLS)) &&
                    (res_o.cursor_row < 5'(tte_pkg::ROWS)))
    else $error("reported cursor outside the screen");

  a_offset_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.cursor_offset == 11'(13'(res_o.cursor_col) +
                    13'(tte_pkg::COLS) * 13'(res_o.cursor_row)))
    else $error("cursor offset does not match column and row");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid && !res_o.valid)
    else $error("command dispatched from empty queue or over pending result");

endmodule

[bench/tte_char_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the text terminal character engine: mirrors the screen buffer,
// cursor and text attribute, predicts one report per request and checks res.
// Depends on tte_pkg and the tte_req_if, tte_cfg_if and tte_res_if interfaces.
module tte_char_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tte_req_if   req_i,
  tte_cfg_if   cfg_i,
  tte_res_if   res_i,
  output int   err_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] offset;
    logic        scrolled;
    logic [7:0]  chr;
    logic [7:0]  attr;
  } cursor_report_t;

  cursor_report_t             report_q[$];
  logic [tte_pkg::CELL_W-1:0] screen_mem [tte_pkg::NCELLS];
  int unsigned                cur_col;
  int unsigned                cur_row;
  logic [7:0]                 text_attr;
  int                         mismatch_cnt;

  function automatic void put_cell(int unsigned c, int unsigned r, logic [7:0] ch);
    if (c < tte_pkg::COLS && r < tte_pkg::ROWS)
      screen_mem[c + tte_pkg::COLS * r] = {text_attr, ch};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < tte_pkg::NCELLS - tte_pkg::COLS; i++)
      screen_mem[i] = screen_mem[i + tte_pkg::COLS];
    for (int c = 0; c < tte_pkg::COLS; c++)
      put_cell(c, tte_pkg::ROWS - 1, tte_pkg::CH_BLANK);
  endfunction

  function automatic cursor_report_t apply_request(logic [1:0] kind, logic [7:0] ch,
                                                   logic [7:0] px, logic [7:0] py);
    cursor_report_t rep;
    int unsigned    offs;
    rep = '0;
    case (kind)
      tte_pkg::KIND_PUT: begin
        if (ch == tte_pkg::CH_NEWLINE) begin
          cur_row++;
          cur_col = 0;
        end else if (ch == tte_pkg::CH_BACKSPACE) begin
          if (cur_col == 0) begin
            // origin stays put, column zero steps to the end of the row above
            if (cur_row != 0) begin
              cur_row--;
              cur_col = tte_pkg::COLS - 1;
            end
          end else begin
            cur_col--;
          end
          put_cell(cur_col, cur_row, tte_pkg::CH_BLANK);
        end else if (ch == tte_pkg::CH_TAB) begin
          put_cell(cur_col, cur_row, tte_pkg::CH_BLANK);
          cur_col++;
          while ((cur_col % 4) != 0 && cur_col < tte_pkg::COLS) begin
            put_cell(cur_col, cur_row, tte_pkg::CH_BLANK);
            cur_col++;
          end
        end else begin
          put_cell(cur_col, cur_row, ch);
          cur_col++;
        end
        if (cur_col >= tte_pkg::COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= tte_pkg::ROWS) begin
          cur_row = tte_pkg::ROWS - 1;
          scroll_screen();
          rep.scrolled = 1'b1;
        end
      end
      tte_pkg::KIND_SET: begin
        // each coordinate applies on its own
        if (px < tte_pkg::COLS) cur_col = 32'(px);
        if (py < tte_pkg::ROWS) cur_row = 32'(py);
      end
      tte_pkg::KIND_CLEAR: begin
        foreach (screen_mem[i]) screen_mem[i] = {text_attr, tte_pkg::CH_BLANK};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        if (px < tte_pkg::COLS && py < tte_pkg::ROWS)
          {rep.attr, rep.chr} = screen_mem[px + tte_pkg::COLS * py];
      end
    endcase
    offs       = cur_col + tte_pkg::COLS * cur_row;
    rep.col    = cur_col[6:0];
    rep.row    = cur_row[4:0];
    rep.offset = offs[10:0];
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_report_t want;
    if (!rst_ni) begin
      foreach (screen_mem[i]) screen_mem[i] = '0;
      cur_col      = 0;
      cur_row      = 0;
      text_attr    = tte_pkg::ATTR_RESET;
      mismatch_cnt = 0;
      report_q.delete();
      err_cnt_o    <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) text_attr = cfg_i.data;
      if (req_i.valid && req_i.ready)
        report_q.push_back(apply_request(req_i.kind, req_i.character, req_i.pos_x,
                                         req_i.pos_y));
      if (res_i.valid && res_i.ready) begin
        if (report_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with no request outstanding", $time);
        end else begin
          want = report_q.pop_front();
          check_field("cursor_col", 32'(want.col), 32'(res_i.cursor_col));
          check_field("cursor_row", 32'(want.row), 32'(res_i.cursor_row));
          check_field("cursor_offset", 32'(want.offset), 32'(res_i.cursor_offset));
          check_field("scrolled", 32'(want.scrolled), 32'(res_i.scrolled));
          check_field("cell_char", 32'(want.chr), 32'(res_i.cell_char));
          check_field("cell_attr", 32'(want.attr), 32'(res_i.cell_attr));
        end
      end
      err_cnt_o <= mismatch_cnt;
      pending_o <= report_q.size();
    end
  end

endmodule

[bench/tb_text_terminal_char_engine_core.sv]
`timescale 1ns / 1ps
// Testbench top for text_terminal_char_engine_core: directed and random requests,
// attribute writes between phases, random stalls on the result side.
// Depends on tte_pkg, the tte_*_if interfaces, the core and tte_char_checker.
module tb_text_terminal_char_engine_core;

  localparam int LONG_GAP    = 40;
  localparam int ITEM_MAX    = 1000;
  localparam int TAIL_CYCLES = 50;
  // every request a full scroll, every gap and stall at its longest, then 4x
  localparam int LIMIT = 4 * (tte_pkg::NCELLS +
                              ITEM_MAX * (tte_pkg::NCELLS + 2 + 2 * LONG_GAP + 10));

  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  int   pending;
  int   cycle_cnt;
  bit   burst_mode;

  tte_req_if req_if();
  tte_cfg_if cfg_if();
  tte_res_if res_if();

  text_terminal_char_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  tte_char_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .cfg_i     (cfg_if),
    .res_i     (res_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, LONG_GAP);
  endfunction

  // columns and rows mostly near the edges, where wraps and scrolls happen
  function automatic logic [7:0] pick_col();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(0, 15));
    if (r < 7) return 8'($urandom_range(tte_pkg::COLS - 16, tte_pkg::COLS - 1));
    return 8'($urandom_range(0, tte_pkg::COLS - 1));
  endfunction

  function automatic logic [7:0] pick_row();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(0, 3));
    if (r < 7) return 8'($urandom_range(tte_pkg::ROWS - 4, tte_pkg::ROWS - 1));
    return 8'($urandom_range(0, tte_pkg::ROWS - 1));
  endfunction

  initial begin
    int gap;
    int run;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [7:0] ch,
                          input logic [7:0] px, input logic [7:0] py);
    int gap;
    req_if.kind      <= kind;
    req_if.character <= ch;
    req_if.pos_x     <= px;
    req_if.pos_y     <= py;
    req_if.valid     <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold requests until every outstanding report is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_attr(input logic [7:0] attr);
    cfg_if.data  <= attr;
    cfg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random_req();
    logic [1:0] kind;
    logic [7:0] ch;
    logic [7:0] px;
    logic [7:0] py;
    int         r;
    // unused fields carry random noise
    ch = 8'($urandom_range(0, 255));
    px = 8'($urandom_range(0, 255));
    py = 8'($urandom_range(0, 255));
    r  = $urandom_range(0, 99);
    if (r < 62) begin
      kind = tte_pkg::KIND_PUT;
      r    = $urandom_range(0, 99);
      if (r < 8) ch = tte_pkg::CH_NEWLINE;
      else if (r < 15) ch = tte_pkg::CH_BACKSPACE;
      else if (r < 22) ch = tte_pkg::CH_TAB;
    end else if (r < 78) begin
      kind = tte_pkg::KIND_SET;
      if ($urandom_range(0, 3) != 0) begin
        px = pick_col();
        py = pick_row();
      end
    end else if (r < 80) begin
      kind = tte_pkg::KIND_CLEAR;
    end else begin
      kind = tte_pkg::KIND_READ;
      if ($urandom_range(0, 6) != 0) begin
        px = pick_col();
        py = pick_row();
      end
    end
    send_req(kind, ch, px, py);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) == 0) drain_results();
      send_random_req();
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    burst_mode       = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     <= 1'b0;
    req_if.kind      <= tte_pkg::KIND_PUT;
    req_if.character <= 8'd0;
    req_if.pos_x     <= 8'd0;
    req_if.pos_y     <= 8'd0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= 8'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset attribute
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_PUT, 8'h41, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_PUT, 8'hFF, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_PUT, 8'h00, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_READ, 8'd0, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_READ, 8'd0, 8'd1, 8'd0);
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_PUT, tte_pkg::CH_BACKSPACE, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd0, 8'd5);
    send_req(tte_pkg::KIND_PUT, tte_pkg::CH_BACKSPACE, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd1, 8'd10);
    send_req(tte_pkg::KIND_PUT, tte_pkg::CH_TAB, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd78, 8'd24);
    send_req(tte_pkg::KIND_PUT, tte_pkg::CH_TAB, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd79, 8'd24);
    send_req(tte_pkg::KIND_PUT, 8'h7E, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_PUT, tte_pkg::CH_NEWLINE, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd200, 8'd3);
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd5, 8'd255);
    send_req(tte_pkg::KIND_SET, 8'd0, 8'd80, 8'd25);
    send_req(tte_pkg::KIND_READ, 8'd0, 8'd80, 8'd0);
    send_req(tte_pkg::KIND_READ, 8'd0, 8'd0, 8'd25);
    send_req(tte_pkg::KIND_READ, 8'd0, 8'd255, 8'd255);
    send_req(tte_pkg::KIND_CLEAR, 8'd0, 8'd0, 8'd0);
    send_req(tte_pkg::KIND_READ, 8'd0, 8'd79, 8'd24);
    drain_results();

    write_attr(8'hFF);
    run_random(300);
    drain_results();
    write_attr(8'h00);
    run_random(300);
    drain_results();
    write_attr(8'($urandom_range(1, 254)));
    run_random(300);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
